[hw/rtl/minmax_column_decimator_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the min/max column decimator
// Shared wrappers so every check uses the same clock, reset and report form.
// ----------------------------------------------------------------------------
`ifndef MINMAX_COLUMN_DECIMATOR_MACROS_SVH
`define MINMAX_COLUMN_DECIMATOR_MACROS_SVH

// Same-cycle or overlapped implication, sampled on clk_i, off during reset.
`define MCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition in one cycle implies an outcome in the next.
`define MCD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[hw/rtl/mcd_pkg.sv]
// ----------------------------------------------------------------------------
// mcd_pkg
// Widths, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mcd_pkg;

  localparam int unsigned SampleW  = 8;
  localparam int unsigned CountW   = 16;
  localparam int unsigned ColW     = 9;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Shared divider: 17-bit dividend covers 2*H*D + D, 9-bit divisor covers 2*D
  localparam int unsigned DivNW    = 17;
  localparam int unsigned DivDW    = 9;
  localparam int unsigned DivCntW  = 5;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgNumSamples = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgNumColumns = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMinLevel   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxLevel   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgNoneCode   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgWindowRows = 3'd5;

  // Register reset values
  localparam logic [CountW-1:0]  RstNumSamples = 16'd8192;
  localparam logic [ColW-1:0]    RstNumColumns = 9'd278;
  localparam logic [SampleW-1:0] RstMinLevel   = 8'd2;
  localparam logic [SampleW-1:0] RstMaxLevel   = 8'd252;
  localparam logic [SampleW-1:0] RstNoneCode   = 8'd0;
  localparam logic [SampleW-1:0] RstWindowRows = 8'd17;

  typedef enum logic {
    DivSrcRatio,
    DivSrcRow
  } div_src_e;

  typedef enum logic {
    RowTop,
    RowBottom
  } row_sel_e;

  typedef struct packed {
    logic     eff_load;   // latch saturated counts and level span
    logic     div_start;
    div_src_e div_src;
    logic     qr_load;    // take N/W quotient and remainder
    logic     step;       // one sample transfer
    row_sel_e row_sel;
    logic     mul_load;
    logic     top_load;
    logic     bot_load;
    logic     out_load;
  } mcd_cmd_t;

  typedef struct packed {
    logic cfg_hit;   // valid register written, record restarts
    logic col_end;   // current sample closes a column
    logic div_done;
    logic out_free;  // output register can take a result this cycle
  } mcd_status_t;

endpackage

[hw/rtl/mcd_divider.sv]
// ----------------------------------------------------------------------------
// mcd_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mcd_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mcd_pkg::DivNW-1:0] dividend_i,
  input  logic [mcd_pkg::DivDW-1:0] divisor_i,
  output logic                      done_o,
  output logic [mcd_pkg::DivNW-1:0] quotient_o,
  output logic [mcd_pkg::DivDW-1:0] remainder_o
);
  import mcd_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivNW-1:0]   quo_q;
  logic [DivDW-1:0]   rem_q;
  logic [DivDW-1:0]   den_q;
  logic [DivDW+1:0]   trial;
  logic               fits;

  // partial remainder stays below the divisor, so one extra bit catches the borrow
  assign trial = {1'b0, rem_q, quo_q[DivNW-1]} - {2'b00, den_q};
  assign fits  = ~trial[DivDW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivNW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivNW-2:0], fits};
      rem_q <= fits ? trial[DivDW-1:0] : {rem_q[DivDW-2:0], quo_q[DivNW-1]};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

[hw/rtl/mcd_datapath.sv]
// ----------------------------------------------------------------------------
// mcd_datapath
// Config registers, column tracking, min/max, row scaling and output register.
// ----------------------------------------------------------------------------
module mcd_datapath #(
  parameter int unsigned MAX_SAMPLES = 32768,
  parameter int unsigned MAX_COLUMNS = 300
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mcd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mcd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [mcd_pkg::SampleW-1:0]  sample_i,
  input  mcd_pkg::mcd_cmd_t            cmd_i,
  output mcd_pkg::mcd_status_t         status_o,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [mcd_pkg::ColW-1:0]     column_o,
  output logic [mcd_pkg::SampleW-1:0]  top_row_o,
  output logic [mcd_pkg::SampleW-1:0]  bottom_row_o,
  output logic                         top_missing_o,
  output logic                         bottom_missing_o,
  output logic                         last_column_o
);
  import mcd_pkg::*;

  // configuration
  logic [CountW-1:0]  ns_q;
  logic [ColW-1:0]    nc_q;
  logic [SampleW-1:0] minl_q, maxl_q, none_q, rows_q;
  logic               cfg_hit;

  // effective values
  logic [CountW-1:0]  n_eff, n_q, q_q;
  logic [ColW-1:0]    w_eff, w_q, r_q;
  logic [SampleW-1:0] d_q;
  logic               degen_q;

  // record state
  logic [CountW-1:0]  smp_idx_q, col_start_q;
  logic [ColW-1:0]    col_idx_q, rr_q;
  logic [SampleW-1:0] run_min_q, run_max_q, prev_min_q, prev_max_q;

  // step logic
  logic [CountW-1:0]  span, end_idx, cs_next;
  logic               active, col_end, last, rec_end;
  logic [SampleW-1:0] new_min, new_max, jmax, jmin;
  logic [ColW:0]      rr_sum;
  logic               rr_wrap;
  logic [ColW-1:0]    rr_next;

  // closed column
  logic [SampleW-1:0] hold_jmax_q, hold_jmin_q;
  logic [ColW-1:0]    hold_col_q;
  logic               hold_last_q;

  // row scaling
  logic [SampleW-1:0] row_v, row_c, diff;
  logic [CountW-1:0]  prod_q;
  logic [DivNW-1:0]   div_num;
  logic [DivDW-1:0]   div_den;
  logic               div_done;
  logic [DivNW-1:0]   div_quo;
  logic [DivDW-1:0]   div_rem;
  logic [SampleW-1:0] top_row_q, bot_row_q;

  // output register
  logic               out_valid_q;
  logic [ColW-1:0]    out_col_q;
  logic [SampleW-1:0] out_top_q, out_bot_q;
  logic               out_tmiss_q, out_bmiss_q, out_last_q;

  always_comb begin
    case (cfg_index_i)
      CfgNumSamples, CfgNumColumns, CfgMinLevel,
      CfgMaxLevel, CfgNoneCode, CfgWindowRows: cfg_hit = cfg_we_i;
      default:                                 cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ns_q   <= RstNumSamples;
      nc_q   <= RstNumColumns;
      minl_q <= RstMinLevel;
      maxl_q <= RstMaxLevel;
      none_q <= RstNoneCode;
      rows_q <= RstWindowRows;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgNumSamples: ns_q   <= cfg_data_i;
        CfgNumColumns: nc_q   <= cfg_data_i[ColW-1:0];
        CfgMinLevel:   minl_q <= cfg_data_i[SampleW-1:0];
        CfgMaxLevel:   maxl_q <= cfg_data_i[SampleW-1:0];
        CfgNoneCode:   none_q <= cfg_data_i[SampleW-1:0];
        CfgWindowRows: rows_q <= cfg_data_i[SampleW-1:0];
        default: ;
      endcase
    end
  end

  // saturate counts to 1..MAX
  always_comb begin
    if (ns_q == '0) begin
      n_eff = CountW'(1);
    end else if (32'(ns_q) > 32'(MAX_SAMPLES)) begin
      n_eff = CountW'(MAX_SAMPLES);
    end else begin
      n_eff = ns_q;
    end
    if (nc_q == '0) begin
      w_eff = ColW'(1);
    end else if (32'(nc_q) > 32'(MAX_COLUMNS)) begin
      w_eff = ColW'(MAX_COLUMNS);
    end else begin
      w_eff = nc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eff_load) begin
      n_q     <= n_eff;
      w_q     <= w_eff;
      d_q     <= maxl_q - minl_q;
      degen_q <= (maxl_q <= minl_q);
    end
    if (cmd_i.qr_load) begin
      q_q <= div_quo[CountW-1:0];
      r_q <= div_rem;
    end
  end

  // column step
  always_comb begin
    span    = (q_q == '0) ? CountW'(1) : q_q;
    end_idx = col_start_q + span - CountW'(1);
    active  = (col_idx_q < w_q) && (smp_idx_q >= col_start_q);
    col_end = active && (smp_idx_q == end_idx);
    new_min = (sample_i < run_min_q) ? sample_i : run_min_q;
    new_max = (sample_i > run_max_q) ? sample_i : run_max_q;
    jmax    = new_max;
    jmin    = new_min;
    if (col_idx_q != '0) begin
      if (new_max < prev_min_q) jmax = prev_min_q;
      if (new_min > prev_max_q) jmin = prev_max_q;
    end
    last    = (col_idx_q == w_q - ColW'(1)) || (end_idx == n_q - CountW'(1));
    rr_sum  = {1'b0, rr_q} + {1'b0, r_q};
    rr_wrap = (rr_sum >= {1'b0, w_q});
    rr_next = rr_wrap ? ColW'(rr_sum - {1'b0, w_q}) : rr_sum[ColW-1:0];
    cs_next = (q_q == '0) ? end_idx + CountW'(1)
                          : col_start_q + q_q + CountW'(rr_wrap);
    rec_end = (smp_idx_q >= n_q - CountW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_idx_q   <= '0;
      col_idx_q   <= '0;
      col_start_q <= '0;
      rr_q        <= '0;
      run_min_q   <= '1;
      run_max_q   <= '0;
      prev_min_q  <= '0;
      prev_max_q  <= '0;
    end else if (cfg_hit) begin
      smp_idx_q   <= '0;
      col_idx_q   <= '0;
      col_start_q <= '0;
      rr_q        <= '0;
      run_min_q   <= '1;
      run_max_q   <= '0;
    end else if (cmd_i.step) begin
      if (col_end) begin
        prev_min_q <= new_min;
        prev_max_q <= new_max;
      end
      if (rec_end) begin
        smp_idx_q   <= '0;
        col_idx_q   <= '0;
        col_start_q <= '0;
        rr_q        <= '0;
        run_min_q   <= '1;
        run_max_q   <= '0;
      end else begin
        smp_idx_q <= smp_idx_q + CountW'(1);
        if (col_end) begin
          run_min_q   <= '1;
          run_max_q   <= '0;
          col_idx_q   <= last ? w_q : col_idx_q + ColW'(1);
          col_start_q <= cs_next;
          if (q_q != '0) rr_q <= rr_next;
        end else if (active) begin
          run_min_q <= new_min;
          run_max_q <= new_max;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && col_end) begin
      hold_jmax_q <= jmax;
      hold_jmin_q <= jmin;
      hold_col_q  <= col_idx_q;
      hold_last_q <= last;
    end
  end

  // row = floor((2*H*(max - v) + D) / (2*D)), v clamped to the level span
  always_comb begin
    row_v = (cmd_i.row_sel == RowTop) ? hold_jmax_q : hold_jmin_q;
    if (row_v < minl_q) begin
      row_c = minl_q;
    end else if (row_v > maxl_q) begin
      row_c = maxl_q;
    end else begin
      row_c = row_v;
    end
    diff = maxl_q - row_c;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) prod_q <= {8'd0, rows_q} * {8'd0, diff};
  end

  always_comb begin
    if (cmd_i.div_src == DivSrcRatio) begin
      div_num = {1'b0, n_q};
      div_den = w_q;
    end else begin
      div_num = {prod_q, 1'b0} + DivNW'(d_q);
      div_den = {d_q, 1'b0};
    end
  end

  mcd_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.top_load) begin
      top_row_q <= ((hold_jmax_q == none_q) || degen_q) ? '0 : div_quo[SampleW-1:0];
    end
    if (cmd_i.bot_load) begin
      bot_row_q <= ((hold_jmin_q == none_q) || degen_q) ? '0 : div_quo[SampleW-1:0];
    end
    if (cmd_i.out_load) begin
      out_col_q   <= hold_col_q;
      out_top_q   <= top_row_q;
      out_bot_q   <= bot_row_q;
      out_tmiss_q <= (hold_jmax_q == none_q);
      out_bmiss_q <= (hold_jmin_q == none_q);
      out_last_q  <= hold_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.cfg_hit  = cfg_hit;
  assign status_o.col_end  = col_end;
  assign status_o.div_done = div_done;
  assign status_o.out_free = ~out_valid_q | ~out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign column_o         = out_col_q;
  assign top_row_o        = out_top_q;
  assign bottom_row_o     = out_bot_q;
  assign top_missing_o    = out_tmiss_q;
  assign bottom_missing_o = out_bmiss_q;
  assign last_column_o    = out_last_q;

endmodule

[hw/rtl/mcd_ctrl.sv]
// ----------------------------------------------------------------------------
// mcd_ctrl
// Sequencer: ratio setup, sample intake, per-column row scaling, output load.
// ----------------------------------------------------------------------------
module mcd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mcd_pkg::mcd_status_t status_i,
  output mcd_pkg::mcd_cmd_t    cmd_o
);
  import mcd_pkg::*;

  typedef enum logic [3:0] {
    StEff,
    StQrStart,
    StQrWait,
    StRun,
    StMulTop,
    StDivTop,
    StWaitTop,
    StMulBot,
    StDivBot,
    StWaitBot,
    StOut
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StEff;
    end else if (status_i.cfg_hit) begin
      state_q <= StEff;
    end else begin
      case (state_q)
        StEff:     state_q <= StQrStart;
        StQrStart: state_q <= StQrWait;
        StQrWait:  if (status_i.div_done) state_q <= StRun;
        StRun:     if (in_valid_i && status_i.col_end) state_q <= StMulTop;
        StMulTop:  state_q <= StDivTop;
        StDivTop:  state_q <= StWaitTop;
        StWaitTop: if (status_i.div_done) state_q <= StMulBot;
        StMulBot:  state_q <= StDivBot;
        StDivBot:  state_q <= StWaitBot;
        StWaitBot: if (status_i.div_done) state_q <= StOut;
        StOut:     if (status_i.out_free) state_q <= StRun;
        default:   state_q <= StEff;
      endcase
    end
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.div_src = DivSrcRow;
    cmd_o.row_sel = RowTop;
    case (state_q)
      StEff:     cmd_o.eff_load = 1'b1;
      StQrStart: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_src   = DivSrcRatio;
      end
      StQrWait:  cmd_o.qr_load = status_i.div_done;
      StRun:     cmd_o.step = in_valid_i;
      StMulTop:  cmd_o.mul_load = 1'b1;
      StDivTop:  cmd_o.div_start = 1'b1;
      StWaitTop: cmd_o.top_load = status_i.div_done;
      StMulBot:  begin
        cmd_o.mul_load = 1'b1;
        cmd_o.row_sel  = RowBottom;
      end
      StDivBot:  begin
        cmd_o.div_start = 1'b1;
        cmd_o.row_sel   = RowBottom;
      end
      StWaitBot: cmd_o.bot_load = status_i.div_done;
      StOut:     cmd_o.out_load = status_i.out_free;
      default:   ;
    endcase
  end

  assign in_stall_o = (state_q != StRun);

endmodule

[hw/rtl/minmax_column_decimator.sv]
// ----------------------------------------------------------------------------
// minmax_column_decimator
// Min/max decimation of one sample record into display columns.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_stall_o / sample_i): one sample code per
//    transfer, in record order. Samples outside any column are consumed and
//    dropped; the record wraps after num_samples samples.
//  - Output channel (out_valid_o / out_stall_i): one transfer per finished
//    column with its index, top and bottom screen rows, no-data flags and a
//    last-column flag.
//  - Config port (cfg_we_i / cfg_index_i / cfg_data_i): write only while the
//    block is idle. A write to a known register restarts the record.
// Timing:
//  - Samples inside a column are taken one per cycle.
//  - The sample that closes a column holds off input through two row
//    scalings, each a multiply plus a 17-step shared serial divide, and
//    until the output register can take the result.
//  - After reset and after every write to a known register, the block
//    divides num_samples by num_columns (same divider); input is stalled.
// Stall: a result waits in the output register; samples keep flowing, and
//  only the next column's finish waits for the register to empty.
// ----------------------------------------------------------------------------
module minmax_column_decimator #(
  parameter int unsigned MAX_COLUMNS = 300,
  parameter int unsigned MAX_SAMPLES = 32768
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [mcd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mcd_pkg::CfgDataW-1:0] cfg_data_i,
  // sample input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mcd_pkg::SampleW-1:0]  sample_i,
  // column output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mcd_pkg::ColW-1:0]     column_o,
  output logic [mcd_pkg::SampleW-1:0]  top_row_o,
  output logic [mcd_pkg::SampleW-1:0]  bottom_row_o,
  output logic                         top_missing_o,
  output logic                         bottom_missing_o,
  output logic                         last_column_o
);
  import mcd_pkg::*;

  mcd_cmd_t    cmd;
  mcd_status_t status;

  // sequencer: owns the input stall, steps the datapath through each column
  mcd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // registers, counters, min/max, scaling and the output register
  mcd_datapath #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .sample_i        (sample_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .column_o        (column_o),
    .top_row_o       (top_row_o),
    .bottom_row_o    (bottom_row_o),
    .top_missing_o   (top_missing_o),
    .bottom_missing_o(bottom_missing_o),
    .last_column_o   (last_column_o)
  );

endmodule

[hw/rtl/mcd_checker.sv]
// ----------------------------------------------------------------------------
// mcd_port_checks
// Port-level checks for the column decimator, bound to the top level.
// ----------------------------------------------------------------------------
`include "minmax_column_decimator_macros.svh"

module mcd_port_checks (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [mcd_pkg::ColW-1:0]     column_o,
  input logic [mcd_pkg::SampleW-1:0]  top_row_o,
  input logic [mcd_pkg::SampleW-1:0]  bottom_row_o,
  input logic                         top_missing_o,
  input logic                         bottom_missing_o,
  input logic                         last_column_o
);

  // held result keeps its column and last-column flag while stalled
  `MCD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(column_o) && $stable(last_column_o), "output changed while stalled")

  // joined max never maps below joined min on screen
  `MCD_ASSERT(a_row_order, out_valid_o && !top_missing_o && !bottom_missing_o |-> top_row_o <= bottom_row_o, "top row below bottom row")

  // no-data values report row zero
  `MCD_ASSERT(a_top_miss_zero, out_valid_o && top_missing_o |-> top_row_o == 8'd0, "missing top with nonzero row")

  `MCD_ASSERT(a_bot_miss_zero, out_valid_o && bottom_missing_o |-> bottom_row_o == 8'd0, "missing bottom with nonzero row")

endmodule

bind minmax_column_decimator mcd_port_checks u_mcd_port_checks (.*);
